// File: sv/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants and types of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Default screen geometry.
  localparam int DEF_SCREEN_WIDTH  = 80;
  localparam int DEF_SCREEN_HEIGHT = 25;

  // Field widths.
  localparam int CELL_W      = 16;
  localparam int CHAR_W      = 8;
  localparam int COLOR_W     = 4;
  localparam int ROW_FIELD_W = 5;
  localparam int COL_FIELD_W = 7;
  localparam int CFG_IDX_W   = 1;

  // Command codes.
  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 1'b1;

  // Reset colors.
  localparam logic [COLOR_W-1:0] FG_RESET = 4'h2;
  localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;

  // Control characters.
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  // A newline leaves a black-on-black marker cell behind.
  localparam logic [CELL_W-1:0] NL_CELL = {8'h00, CH_NEWLINE};

  typedef struct packed {
    logic [CELL_W-1:0]      cell_word;
    logic [ROW_FIELD_W-1:0] cursor_row;
    logic [COL_FIELD_W-1:0] cursor_col;
  } res_t;

endpackage

// File: sv/tcw_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_engine
// Screen memory and the sequencer that reads, writes and scrolls it.
// ----------------------------------------------------------------------------
module tcw_engine #(
  parameter int SCREEN_WIDTH  = tcw_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = tcw_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           ready_o,
  input  logic                           cmd_i,
  input  logic [tcw_pkg::CHAR_W-1:0]      char_code_i,
  input  logic [tcw_pkg::ROW_FIELD_W-1:0] read_row_i,
  input  logic [tcw_pkg::COL_FIELD_W-1:0] read_col_i,
  input  logic [tcw_pkg::COLOR_W-1:0]     fg_i,
  input  logic [tcw_pkg::COLOR_W-1:0]     bg_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output tcw_pkg::res_t                  res_o
);
  import tcw_pkg::*;

  localparam int DEPTH  = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int COL_W  = $clog2(SCREEN_WIDTH);
  localparam int ROW_W  = $clog2(SCREEN_HEIGHT);
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [9:0] {
    ST_INIT    = 10'b00_0000_0001,
    ST_IDLE    = 10'b00_0000_0010,
    ST_RD_WAIT = 10'b00_0000_0100,
    ST_PUT     = 10'b00_0000_1000,
    ST_BACK    = 10'b00_0001_0000,
    ST_SCAN_RD = 10'b00_0010_0000,
    ST_SCAN_CK = 10'b00_0100_0000,
    ST_SHIFT   = 10'b00_1000_0000,
    ST_CLEAR   = 10'b01_0000_0000,
    ST_DONE    = 10'b10_0000_0000
  } state_e;

  function automatic logic [CNT_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                 input logic [COL_W-1:0] c);
    return CNT_W'(r) * CNT_W'(SCREEN_WIDTH) + CNT_W'(c);
  endfunction

  state_e              state_q, state_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [CHAR_W-1:0]   ch_q, ch_d;
  logic                nl_q, nl_d;
  logic                tab_q, tab_d;
  logic                bs_q, bs_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                shp_q, shp_d;
  logic [ADDR_W-1:0]   shdst_q, shdst_d;
  logic [CELL_W-1:0]   word_q, word_d;

  logic [CELL_W-1:0]   mem_q [DEPTH];
  logic [CELL_W-1:0]   rdata_q;
  logic                we, re;
  logic [ADDR_W-1:0]   waddr, raddr;
  logic [CELL_W-1:0]   wdata;

  logic                finish, back_done, scan_done, rd_in_range;

  assign rd_in_range = (32'(read_row_i) < SCREEN_HEIGHT) && (32'(read_col_i) < SCREEN_WIDTH);
  assign ready_o     = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    row_d     = row_q;
    col_d     = col_q;
    ch_d      = ch_q;
    nl_d      = nl_q;
    tab_d     = tab_q;
    bs_d      = bs_q;
    cnt_d     = cnt_q;
    shp_d     = 1'b0;
    shdst_d   = shdst_q;
    word_d    = word_q;
    we        = 1'b0;
    re        = 1'b0;
    waddr     = '0;
    raddr     = '0;
    wdata     = '0;
    finish    = 1'b0;
    back_done = 1'b0;
    scan_done = 1'b0;

    unique case (state_q)
      ST_INIT: begin
        // Clearing pass: one cell per cycle after reset.
        we    = 1'b1;
        waddr = cnt_q[ADDR_W-1:0];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          word_d = '0;
          nl_d   = 1'b0;
          tab_d  = 1'b0;
          bs_d   = 1'b0;
          if (cmd_i == CMD_READ) begin
            if (rd_in_range) begin
              re      = 1'b1;
              raddr   = ADDR_W'(cell_addr(ROW_W'(read_row_i), COL_W'(read_col_i)));
              state_d = ST_RD_WAIT;
            end else begin
              finish = 1'b1;
            end
          end else begin
            unique case (char_code_i)
              CH_NEWLINE: begin
                nl_d    = 1'b1;
                state_d = ST_PUT;
              end
              CH_RETURN: finish = 1'b1;
              CH_TAB: begin
                ch_d    = CH_SPACE;
                tab_d   = 1'b1;
                state_d = ST_PUT;
              end
              CH_BACKSPACE: begin
                ch_d    = CH_SPACE;
                bs_d    = 1'b1;
                state_d = ST_BACK;
              end
              default: begin
                ch_d    = char_code_i;
                state_d = ST_PUT;
              end
            endcase
          end
        end
      end
      ST_RD_WAIT: begin
        word_d = rdata_q;
        finish = 1'b1;
      end
      ST_PUT: begin
        we    = 1'b1;
        waddr = ADDR_W'(cell_addr(row_q, col_q));
        if (nl_q) begin
          wdata = NL_CELL;
          nl_d  = 1'b0;
          col_d = '0;
          row_d = (row_q == ROW_W'(SCREEN_HEIGHT - 1)) ? '0 : row_q + 1'b1;
          finish = 1'b1;
        end else begin
          wdata = {bg_i, fg_i, ch_q};
          if (col_q == COL_W'(SCREEN_WIDTH - 1)) begin
            col_d = '0;
            row_d = (row_q == ROW_W'(SCREEN_HEIGHT - 1)) ? '0 : row_q + 1'b1;
          end else begin
            col_d = col_q + 1'b1;
          end
          if (tab_q) begin
            tab_d = 1'b0;
          end else if (bs_q) begin
            // Second step back of a backspace.
            bs_d    = 1'b0;
            state_d = ST_BACK;
          end else begin
            finish = 1'b1;
          end
        end
      end
      ST_BACK: begin
        if (col_q != '0) begin
          col_d     = col_q - 1'b1;
          back_done = 1'b1;
        end else begin
          row_d   = (row_q != '0) ? row_q - 1'b1 : row_q;
          col_d   = COL_W'(SCREEN_WIDTH - 1);
          state_d = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        if (col_q == '0) begin
          scan_done = 1'b1;
        end else begin
          re      = 1'b1;
          raddr   = ADDR_W'(cell_addr(row_q, col_q));
          state_d = ST_SCAN_CK;
        end
      end
      ST_SCAN_CK: begin
        if (rdata_q[CHAR_W-1:0] == CH_NEWLINE) begin
          scan_done = 1'b1;
        end else begin
          col_d   = col_q - 1'b1;
          state_d = ST_SCAN_RD;
        end
      end
      ST_SHIFT: begin
        // Read one cell per cycle and write it one row up in the next cycle.
        we    = shp_q;
        waddr = shdst_q;
        wdata = rdata_q;
        if (cnt_q < CNT_W'(DEPTH)) begin
          re      = 1'b1;
          raddr   = cnt_q[ADDR_W-1:0];
          shp_d   = 1'b1;
          shdst_d = ADDR_W'(cnt_q - CNT_W'(SCREEN_WIDTH));
          cnt_d   = cnt_q + 1'b1;
        end else begin
          cnt_d   = CNT_W'((SCREEN_HEIGHT - 1) * SCREEN_WIDTH);
          state_d = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = cnt_q[ADDR_W-1:0];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DEPTH - 1)) begin
          back_done = 1'b1;
        end
      end
      ST_DONE: finish = 1'b1;
      default: state_d = ST_IDLE;
    endcase

    // Rows from the cursor row plus two to the last row move up by one row.
    if (scan_done) begin
      if ((32'(row_q) + 2) < SCREEN_HEIGHT) begin
        cnt_d   = cell_addr(row_q + ROW_W'(2), '0);
        state_d = ST_SHIFT;
      end else begin
        cnt_d   = CNT_W'((SCREEN_HEIGHT - 1) * SCREEN_WIDTH);
        state_d = ST_CLEAR;
      end
    end

    // The first step back of a backspace is followed by the space.
    if (back_done) begin
      if (bs_q) begin
        state_d = ST_PUT;
      end else begin
        finish = 1'b1;
      end
    end

    res_valid_o      = 1'b0;
    res_o.cell_word  = word_d;
    res_o.cursor_row = ROW_FIELD_W'(row_d);
    res_o.cursor_col = COL_FIELD_W'(col_d);
    if (finish) begin
      if (res_ready_i) begin
        res_valid_o = 1'b1;
        state_d     = ST_IDLE;
      end else begin
        state_d = ST_DONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      row_q   <= '0;
      col_q   <= '0;
      nl_q    <= 1'b0;
      tab_q   <= 1'b0;
      bs_q    <= 1'b0;
      cnt_q   <= '0;
      shp_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      nl_q    <= nl_d;
      tab_q   <= tab_d;
      bs_q    <= bs_d;
      cnt_q   <= cnt_d;
      shp_q   <= shp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q    <= ch_d;
    shdst_q <= shdst_d;
    word_q  <= word_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(row_q) < SCREEN_HEIGHT) && (32'(col_q) < SCREEN_WIDTH))
    else $error("cursor left the screen");

  a_no_same_addr_rw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(we && re && (waddr == raddr)))
    else $error("read and write of the same cell in one cycle");

  a_shift_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT) && shp_q && re |-> (shdst_q < raddr))
    else $error("scroll write overtook its source");

  a_result_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> res_ready_i)
    else $error("result handed over while the output register is full");

endmodule

// File: sv/text_console_char_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_writer
// Text console writer with a screen memory, a cursor and scrolling.
// ----------------------------------------------------------------------------
// The input channel takes one beat per command: cmd_i selects a character put
// or a cell read. Every beat yields one result beat on the output channel with
// the cell read (zero for a put) and the cursor after the command.
// Before its result reaches the output register, a read waits for the screen
// memory, an ordinary character or a newline writes one cell, a tab writes two
// spaces, a carriage return writes nothing and a backspace away from column 0
// steps back, writes a space and steps back again. A backspace that steps back
// across a line start scans the row to the left column by column and then
// scrolls the screen below the cursor one cell per cycle through the single
// write port of the screen memory, and then blanks the last row.
// The block works on one command at a time; a new beat is taken as soon as
// the previous one has been handed to the output register.
// After reset the screen memory is cleared one cell per cycle; no input beat
// is taken meanwhile, while configuration writes are.
// A stalled receiver holds the result in the output register; the next
// command may run but waits for the register before it completes.
// ----------------------------------------------------------------------------
module text_console_char_writer #(
  parameter int SCREEN_WIDTH  = tcw_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = tcw_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            cmd_i,
  input  logic [tcw_pkg::CHAR_W-1:0]      char_code_i,
  input  logic [tcw_pkg::ROW_FIELD_W-1:0] read_row_i,
  input  logic [tcw_pkg::COL_FIELD_W-1:0] read_col_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [tcw_pkg::CELL_W-1:0]      cell_word_o,
  output logic [tcw_pkg::ROW_FIELD_W-1:0] cursor_row_o,
  output logic [tcw_pkg::COL_FIELD_W-1:0] cursor_col_o,
  input  logic                            cfg_we_i,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tcw_pkg::COLOR_W-1:0]     cfg_data_i
);
  import tcw_pkg::*;

  logic [COLOR_W-1:0] fg_q, bg_q;
  logic               out_valid_q, out_valid_d;
  res_t               out_q;
  res_t               res;
  logic               res_valid, out_free, eng_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= FG_RESET;
      bg_q <= BG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FOREGROUND: fg_q <= cfg_data_i;
        CFG_BACKGROUND: bg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = eng_ready;

  tcw_engine #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_valid_i && eng_ready),
    .ready_o    (eng_ready),
    .cmd_i      (cmd_i),
    .char_code_i(char_code_i),
    .read_row_i (read_row_i),
    .read_col_i (read_col_i),
    .fg_i       (fg_q),
    .bg_i       (bg_q),
    .res_valid_o(res_valid),
    .res_ready_i(out_free),
    .res_o      (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cell_word_o  = out_q.cell_word;
  assign cursor_row_o = out_q.cursor_row;
  assign cursor_col_o = out_q.cursor_col;

endmodule
